### sv/chse_pkg.sv
// Shared types, constants and helper functions for the cubic Hermite spline evaluator.
// Used by the top level and by its port checker; depends on nothing else.
package chse_pkg;

    // Sizes
    localparam int MAX_KNOTS = 64;
    localparam int FRAC_BITS = 16;
    localparam int DW        = 32;                       // value / position width
    localparam int IDX_W     = $clog2(MAX_KNOTS);        // interval index
    localparam int CNT_W     = $clog2(MAX_KNOTS + 1);    // knot count
    localparam int CW        = 48;                       // coefficient c / d width
    localparam int NUM_W     = 2 * DW + 4;               // signed coefficient numerator
    localparam int MAG_W     = NUM_W - 1;                // numerator magnitude
    localparam int DVD_W     = MAG_W + 2 * FRAC_BITS;    // widest dividend
    localparam int QW        = CW;                       // quotient bits produced
    localparam int DVS_W     = 3 * DW;                   // divisor (h cubed)
    localparam int PROD_W    = 3 * DW;                   // 64 x 32 product
    localparam int QCNT_W    = $clog2(QW);
    localparam int STEP_W    = 4;

    // Stream widths
    localparam int S_TDATA_W = 3 * DW;
    localparam int M_TDATA_W = ((3 * DW + CNT_W + 7) / 8) * 8;
    localparam int TUSER_W   = 2;

    // Command codes
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_EVAL   = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FEW   = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_ORDER = 2'd3;

    // One stored interval
    typedef struct packed {
        logic [DW-1:0] start;
        logic [DW-1:0] a;
        logic [DW-1:0] b;
        logic [CW-1:0] c;
        logic [CW-1:0] d;
    } row_t;

    // Evaluation micro-ops
    typedef enum logic [0:0] {
        UOP_MULQ,
        UOP_ADD
    } uop_kind_t;

    typedef enum logic [3:0] {
        R_A, R_B, R_C, R_D, R_C2, R_D3, R_D6,
        R_T0, R_T1, R_T2, R_V, R_S, R_CV
    } rsel_t;

    typedef struct packed {
        uop_kind_t kind;
        rsel_t     sa;
        rsel_t     sb;
        rsel_t     dst;
    } uop_t;

    localparam logic [STEP_W-1:0] UOP_LAST = 4'd15;

    // Evaluation program; every MULQ multiplies its operand by t
    function automatic uop_t uop_rom(input logic [STEP_W-1:0] step);
        uop_t u;
        case (step)
            4'd0:    u = '{UOP_MULQ, R_B,  R_B,  R_T0};  // b*t
            4'd1:    u = '{UOP_MULQ, R_C,  R_C,  R_T1};  // c*t
            4'd2:    u = '{UOP_MULQ, R_T1, R_T1, R_T1};  // c*t*t
            4'd3:    u = '{UOP_MULQ, R_D,  R_D,  R_T2};
            4'd4:    u = '{UOP_MULQ, R_T2, R_T2, R_T2};
            4'd5:    u = '{UOP_MULQ, R_T2, R_T2, R_T2};  // d*t*t*t
            4'd6:    u = '{UOP_ADD,  R_A,  R_T0, R_V};
            4'd7:    u = '{UOP_ADD,  R_T1, R_T2, R_T1};
            4'd8:    u = '{UOP_ADD,  R_V,  R_T1, R_V};   // value
            4'd9:    u = '{UOP_MULQ, R_C2, R_C2, R_T0};
            4'd10:   u = '{UOP_ADD,  R_B,  R_T0, R_S};
            4'd11:   u = '{UOP_MULQ, R_D3, R_D3, R_T0};
            4'd12:   u = '{UOP_MULQ, R_T0, R_T0, R_T0};
            4'd13:   u = '{UOP_ADD,  R_S,  R_T0, R_S};   // slope
            4'd14:   u = '{UOP_MULQ, R_D6, R_D6, R_T0};
            4'd15:   u = '{UOP_ADD,  R_C2, R_T0, R_CV};  // convexity
            default: u = '{UOP_ADD,  R_A,  R_A,  R_T0};
        endcase
        return u;
    endfunction

    // 64-bit saturating add
    function automatic logic signed [63:0] sadd64(input logic signed [63:0] x,
                                                  input logic signed [63:0] y);
        logic signed [64:0] s;
        logic signed [63:0] r;
        s = {x[63], x} + {y[63], y};
        if (s[64] != s[63]) begin
            r = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            r = s[63:0];
        end
        return r;
    endfunction

    // Saturate to 32 bits
    function automatic logic [DW-1:0] sat32(input logic signed [63:0] v);
        logic [DW-1:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            r = 32'h8000_0000;
        end else begin
            r = v[DW-1:0];
        end
        return r;
    endfunction

endpackage

### sv/cubic_hermite_spline_eval.sv
// Cubic Hermite spline evaluator: knot table, coefficient divider and evaluation sequencer.
// Depends on chse_pkg.
//
// Takes one request at a time on the s_ stream (cmd in s_tuser) and returns one result on
// the m_ stream. Knots must arrive in strictly increasing position order; each knot after
// the first builds one interval whose c and d coefficients come from a restoring divider
// that makes one quotient bit per cycle, 48 bits per coefficient. Evaluate runs a binary
// search over the interval table (each probe reads a row in ST_SRD and compares in
// ST_SCMP) and then a 16-step program on one shared 32x32 multiplier and one saturating
// adder. Clear and rejected requests go from idle straight to the finishing state.
// A finished result waits in the output register while the next request is taken.
module cubic_hermite_spline_eval
    import chse_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // position, knot_value, knot_slope
    input  logic [TUSER_W-1:0]   s_tuser,   // cmd
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // value, slope, convexity, knot_count, zero pad
    output logic [TUSER_W-1:0]   m_tuser    // status
);

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_AMUL  = 11'b000_0000_0010,
        ST_DINIT = 11'b000_0000_0100,
        ST_DIV   = 11'b000_0000_1000,
        ST_AWR   = 11'b000_0001_0000,
        ST_SRD   = 11'b000_0010_0000,
        ST_SCMP  = 11'b000_0100_0000,
        ST_LRD   = 11'b000_1000_0000,
        ST_LD    = 11'b001_0000_0000,
        ST_EXEC  = 11'b010_0000_0000,
        ST_FIN   = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // Knot table state
    row_t                  mem [MAX_KNOTS];
    row_t                  rd_row_reg;
    logic [IDX_W-1:0]      rd_addr;
    logic [CNT_W-1:0]      loaded_reg;
    logic signed [DW-1:0]  last_pos_reg, last_val_reg, last_slp_reg;

    // Latched request
    logic signed [DW-1:0]  in_pos_reg, in_val_reg, in_slp_reg;
    logic [1:0]            st_reg;
    logic                  ev_ok_reg;

    // Append datapath
    logic [DW-1:0]         h_reg;
    logic signed [DW+1:0]  u1_reg;
    logic signed [DW:0]    u2_reg;
    logic signed [NUM_W-1:0] ec_reg, ed_reg, nc_reg, nd_reg;
    logic [2*DW-1:0]       h2_reg;
    logic [DVS_W-1:0]      h3_reg;
    logic [1:0]            astep_reg;
    logic                  phase_reg;
    logic [CW-1:0]         cc_reg, dd_reg;

    // Divider
    logic                  dsel_reg, dneg_reg, dovf_reg;
    logic [DVS_W-1:0]      rem_reg, dvs_reg;
    logic [QW-1:0]         nlo_reg, q_reg;
    logic [QCNT_W-1:0]     qcnt_reg;

    // Search / evaluation
    logic signed [DW-1:0]  x_reg;
    logic [IDX_W-1:0]      lo_reg, hi_reg;
    logic [DW-1:0]         tmag_reg;
    logic                  tneg_reg;
    logic [STEP_W-1:0]     step_reg;
    logic signed [63:0]    ra_reg, rb_reg, rc_reg, rd_reg, rc2_reg, rd3_reg, rd6_reg;
    logic signed [63:0]    t0_reg, t1_reg, t2_reg, rv_reg, rs_reg, rcv_reg;

    // Output register
    logic                  m_valid_reg;
    logic [M_TDATA_W-1:0]  m_data_reg;
    logic [TUSER_W-1:0]    m_user_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // Request fields
    logic signed [DW-1:0] s_pos, s_val, s_slp;
    assign s_pos = s_tdata[DW-1:0];
    assign s_val = s_tdata[2*DW-1:DW];
    assign s_slp = s_tdata[3*DW-1:2*DW];

    logic accept;
    assign accept = s_tvalid && (state_reg == ST_IDLE);

    // Append set-up terms
    logic signed [DW:0]      diff_p, dy;
    logic signed [DW+1:0]    u1_new;
    logic signed [DW:0]      u2_new;
    logic signed [NUM_W-1:0] dy_ext, ec_new, ed_new;
    always_comb begin
        diff_p = {s_pos[DW-1], s_pos} - {last_pos_reg[DW-1], last_pos_reg};
        dy     = {s_val[DW-1], s_val} - {last_val_reg[DW-1], last_val_reg};
        u1_new = {last_slp_reg[DW-1], last_slp_reg, 1'b0} + {{2{s_slp[DW-1]}}, s_slp};
        u2_new = {last_slp_reg[DW-1], last_slp_reg} + {s_slp[DW-1], s_slp};
        dy_ext = NUM_W'(dy);
        ec_new = ((dy_ext <<< 1) + dy_ext) <<< FRAC_BITS;
        ed_new = -((dy_ext <<< 1) <<< FRAC_BITS);
    end

    // Operand select for the evaluation program
    uop_t               uop;
    logic signed [63:0] src_a, src_b;
    assign uop = uop_rom(step_reg);

    function automatic logic signed [63:0] pick(input rsel_t s,
        input logic signed [63:0] a, b, c, d, c2, d3, d6, t0, t1, t2, v, sl, cv);
        logic signed [63:0] r;
        case (s)
            R_A:     r = a;
            R_B:     r = b;
            R_C:     r = c;
            R_D:     r = d;
            R_C2:    r = c2;
            R_D3:    r = d3;
            R_D6:    r = d6;
            R_T0:    r = t0;
            R_T1:    r = t1;
            R_T2:    r = t2;
            R_V:     r = v;
            R_S:     r = sl;
            R_CV:    r = cv;
            default: r = '0;
        endcase
        return r;
    endfunction

    assign src_a = pick(uop.sa, ra_reg, rb_reg, rc_reg, rd_reg, rc2_reg, rd3_reg, rd6_reg,
                        t0_reg, t1_reg, t2_reg, rv_reg, rs_reg, rcv_reg);
    assign src_b = pick(uop.sb, ra_reg, rb_reg, rc_reg, rd_reg, rc2_reg, rd3_reg, rd6_reg,
                        t0_reg, t1_reg, t2_reg, rv_reg, rs_reg, rcv_reg);

    // Shared multiplier: 64 x 32 as two 32 x 32 passes
    logic [63:0]        mul_a;
    logic [DW-1:0]      mul_b;
    logic [2*DW-1:0]    mul_p;
    logic [PROD_W-1:0]  acc_reg, acc_next;
    logic [DW+1:0]      u1_mag;
    logic [DW:0]        u2_mag;
    always_comb begin
        u1_mag = u1_reg[DW+1] ? (DW+2)'(0) - u1_reg : u1_reg;
        u2_mag = u2_reg[DW] ? (DW+1)'(0) - u2_reg : u2_reg;
        mul_a  = '0;
        if (state_reg == ST_EXEC) begin
            mul_a = src_a[63] ? 64'd0 - src_a : src_a;
        end else begin
            case (astep_reg)
                2'd0:    mul_a = 64'(u1_mag);
                2'd1:    mul_a = 64'(u2_mag);
                2'd2:    mul_a = 64'(h_reg);
                default: mul_a = h2_reg;
            endcase
        end
        mul_b = (state_reg == ST_EXEC) ? tmag_reg : h_reg;
        mul_p = (phase_reg ? mul_a[63:32] : mul_a[31:0]) * mul_b;
        acc_next = phase_reg ? acc_reg + {mul_p, 32'd0} : PROD_W'(mul_p);
    end

    // Signed numerators from the finished product
    logic [NUM_W-1:0]        p_ext;
    logic signed [NUM_W-1:0] nc_new, nd_new;
    always_comb begin
        p_ext  = NUM_W'(acc_next);
        nc_new = ec_reg - (u1_reg[DW+1] ? -$signed(p_ext) : $signed(p_ext));
        nd_new = ed_reg + (u2_reg[DW] ? -$signed(p_ext) : $signed(p_ext));
    end

    // Fixed-point product: trunc(|x|*|t| / 2^F), saturated, sign applied
    logic [PROD_W-FRAC_BITS-1:0] mq_sh;
    logic [63:0]                 mq_mag;
    logic signed [63:0]          mq_res, add_res;
    always_comb begin
        mq_sh  = acc_next[PROD_W-1:FRAC_BITS];
        mq_mag = (|mq_sh[PROD_W-FRAC_BITS-1:63]) ? {1'b0, {63{1'b1}}} : mq_sh[63:0];
        mq_res = (src_a[63] ^ tneg_reg) ? -$signed(mq_mag) : $signed(mq_mag);
        add_res = sadd64(src_a, src_b);
    end

    // Divider set-up and one restoring step
    logic [MAG_W-1:0]  nmag;
    logic [DVD_W-1:0]  dvd;
    logic [DVS_W-1:0]  dvs_new, top_ext;
    logic              dneg_new;
    logic [DVS_W:0]    r2, r2_sub;
    logic              q_ge;
    logic [QW-1:0]     q_next, q_sat;
    logic [CW-1:0]     coef_new;
    always_comb begin
        dneg_new = dsel_reg ? nd_reg[NUM_W-1] : nc_reg[NUM_W-1];
        nmag     = dsel_reg ? MAG_W'(nd_reg[NUM_W-1] ? -nd_reg : nd_reg)
                            : MAG_W'(nc_reg[NUM_W-1] ? -nc_reg : nc_reg);
        dvd      = dsel_reg ? DVD_W'(nmag) << (2 * FRAC_BITS) : DVD_W'(nmag) << FRAC_BITS;
        dvs_new  = dsel_reg ? h3_reg : DVS_W'(h2_reg);
        top_ext  = DVS_W'(dvd[DVD_W-1:QW]);
        r2       = {rem_reg, nlo_reg[QW-1]};
        r2_sub   = r2 - {1'b0, dvs_reg};
        q_ge     = (r2 >= {1'b0, dvs_reg});
        q_next   = {q_reg[QW-2:0], q_ge};
        // Clamp magnitude to the signed 48-bit range
        if (dovf_reg || (q_next > (QW'({1'b0, {(CW-1){1'b1}}}) + QW'(dneg_reg)))) begin
            q_sat = QW'({1'b0, {(CW-1){1'b1}}}) + QW'(dneg_reg);
        end else begin
            q_sat = q_next;
        end
        coef_new = dneg_reg ? CW'(0) - q_sat : q_sat;
    end

    // Search helpers
    logic [IDX_W:0]   mid_sum;
    logic [IDX_W-1:0] mid, lo_n, hi_n, idx_sel;
    logic [CNT_W-1:0] loaded_m1;
    logic signed [DW:0] t_new;
    always_comb begin
        mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
        mid       = mid_sum[IDX_W:1];
        lo_n      = lo_reg;
        hi_n      = hi_reg;
        if ($signed(rd_row_reg.start) < x_reg) begin
            lo_n = mid + IDX_W'(1);
        end else begin
            hi_n = mid;
        end
        idx_sel   = (lo_reg != '0) ? lo_reg - IDX_W'(1) : '0;
        loaded_m1 = loaded_reg - CNT_W'(1);
        rd_addr   = (state_reg == ST_SRD) ? mid : idx_sel;
        t_new     = {x_reg[DW-1], x_reg} - {rd_row_reg.start[DW-1], rd_row_reg.start};
    end

    // Knot table memory
    always_ff @(posedge aclk) begin
        if (state_reg == ST_AWR) begin
            mem[loaded_m1[IDX_W-1:0]] <= '{last_pos_reg, last_val_reg, last_slp_reg,
                                            cc_reg, dd_reg};
        end
        rd_row_reg <= mem[rd_addr];
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_FIN;
                    if (s_tuser == CMD_APPEND && loaded_reg < CNT_W'(MAX_KNOTS)
                        && loaded_reg != '0 && s_pos > last_pos_reg) begin
                        state_next = ST_AMUL;
                    end else if (s_tuser == CMD_EVAL && loaded_reg >= CNT_W'(3)) begin
                        state_next = ST_SRD;
                    end
                end
            end
            ST_AMUL: begin
                if (phase_reg && astep_reg == 2'd3) begin
                    state_next = ST_DINIT;
                end
            end
            ST_DINIT: state_next = ST_DIV;
            ST_DIV: begin
                if (qcnt_reg == QCNT_W'(QW - 1)) begin
                    state_next = dsel_reg ? ST_AWR : ST_DINIT;
                end
            end
            ST_AWR:  state_next = ST_FIN;
            ST_SRD:  state_next = ST_SCMP;
            ST_SCMP: state_next = (lo_n < hi_n) ? ST_SRD : ST_LRD;
            ST_LRD:  state_next = ST_LD;
            ST_LD:   state_next = ST_EXEC;
            ST_EXEC: begin
                if (step_reg == UOP_LAST) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            loaded_reg   <= '0;
            last_pos_reg <= '0;
            last_val_reg <= '0;
            last_slp_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept && s_tuser == CMD_CLEAR) begin
                loaded_reg   <= '0;
                last_pos_reg <= '0;
                last_val_reg <= '0;
                last_slp_reg <= '0;
            end
            // First knot just opens the table
            if (accept && s_tuser == CMD_APPEND && loaded_reg == '0) begin
                loaded_reg   <= CNT_W'(1);
                last_pos_reg <= s_pos;
                last_val_reg <= s_val;
                last_slp_reg <= s_slp;
            end
            if (state_reg == ST_AWR) begin
                loaded_reg   <= loaded_reg + CNT_W'(1);
                last_pos_reg <= in_pos_reg;
                last_val_reg <= in_val_reg;
                last_slp_reg <= in_slp_reg;
            end
            if (state_reg == ST_FIN && (!m_valid_reg || m_tready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    in_pos_reg <= s_pos;
                    in_val_reg <= s_val;
                    in_slp_reg <= s_slp;
                    h_reg      <= diff_p[DW-1:0];
                    u1_reg     <= u1_new;
                    u2_reg     <= u2_new;
                    ec_reg     <= ec_new;
                    ed_reg     <= ed_new;
                    astep_reg  <= '0;
                    phase_reg  <= 1'b0;
                    dsel_reg   <= 1'b0;
                    x_reg      <= (s_pos > last_pos_reg) ? last_pos_reg : s_pos;
                    lo_reg     <= '0;
                    hi_reg     <= loaded_m1[IDX_W-1:0];
                    case (s_tuser)
                        CMD_APPEND: begin
                            ev_ok_reg <= 1'b0;
                            if (loaded_reg >= CNT_W'(MAX_KNOTS)) begin
                                st_reg <= ST_FULL;
                            end else if (loaded_reg != '0 && s_pos <= last_pos_reg) begin
                                st_reg <= ST_ORDER;
                            end else begin
                                st_reg <= ST_OK;
                            end
                        end
                        CMD_EVAL: begin
                            if (loaded_reg < CNT_W'(3)) begin
                                st_reg    <= ST_FEW;
                                ev_ok_reg <= 1'b0;
                            end else begin
                                st_reg    <= ST_OK;
                                ev_ok_reg <= 1'b1;
                            end
                        end
                        default: begin
                            st_reg    <= ST_OK;
                            ev_ok_reg <= 1'b0;
                        end
                    endcase
                end
            end
            ST_AMUL: begin
                acc_reg   <= acc_next;
                phase_reg <= ~phase_reg;
                if (phase_reg) begin
                    astep_reg <= astep_reg + 2'd1;
                    case (astep_reg)
                        2'd0:    nc_reg <= nc_new;
                        2'd1:    nd_reg <= nd_new;
                        2'd2:    h2_reg <= acc_next[2*DW-1:0];
                        default: h3_reg <= acc_next[DVS_W-1:0];
                    endcase
                end
            end
            ST_DINIT: begin
                dneg_reg <= dneg_new;
                dvs_reg  <= dvs_new;
                dovf_reg <= (top_ext >= dvs_new);
                rem_reg  <= top_ext;
                nlo_reg  <= dvd[QW-1:0];
                q_reg    <= '0;
                qcnt_reg <= '0;
            end
            ST_DIV: begin
                rem_reg  <= q_ge ? r2_sub[DVS_W-1:0] : r2[DVS_W-1:0];
                nlo_reg  <= {nlo_reg[QW-2:0], 1'b0};
                q_reg    <= q_next;
                qcnt_reg <= qcnt_reg + QCNT_W'(1);
                if (qcnt_reg == QCNT_W'(QW - 1)) begin
                    dsel_reg <= 1'b1;
                    if (dsel_reg) begin
                        dd_reg <= coef_new;
                    end else begin
                        cc_reg <= coef_new;
                    end
                end
            end
            ST_SCMP: begin
                lo_reg <= lo_n;
                hi_reg <= hi_n;
            end
            // Unpack the chosen interval
            ST_LD: begin
                tneg_reg  <= t_new[DW];
                tmag_reg  <= t_new[DW] ? DW'(-t_new) : t_new[DW-1:0];
                ra_reg    <= 64'(signed'(rd_row_reg.a));
                rb_reg    <= 64'(signed'(rd_row_reg.b));
                rc_reg    <= 64'(signed'(rd_row_reg.c));
                rd_reg    <= 64'(signed'(rd_row_reg.d));
                rc2_reg   <= 64'(signed'(rd_row_reg.c)) <<< 1;
                rd3_reg   <= (64'(signed'(rd_row_reg.d)) <<< 1) + 64'(signed'(rd_row_reg.d));
                rd6_reg   <= (64'(signed'(rd_row_reg.d)) <<< 2)
                             + (64'(signed'(rd_row_reg.d)) <<< 1);
                step_reg  <= '0;
                phase_reg <= 1'b0;
            end
            // One micro-op: MULQ runs a low-half and then a high-half multiplier pass; ADD completes at once
            ST_EXEC: begin
                if (uop.kind == UOP_MULQ && !phase_reg) begin
                    acc_reg   <= acc_next;
                    phase_reg <= 1'b1;
                end else begin
                    phase_reg <= 1'b0;
                    step_reg  <= step_reg + STEP_W'(1);
                    case (uop.dst)
                        R_T0:    t0_reg  <= (uop.kind == UOP_MULQ) ? mq_res : add_res;
                        R_T1:    t1_reg  <= (uop.kind == UOP_MULQ) ? mq_res : add_res;
                        R_T2:    t2_reg  <= (uop.kind == UOP_MULQ) ? mq_res : add_res;
                        R_V:     rv_reg  <= add_res;
                        R_S:     rs_reg  <= add_res;
                        R_CV:    rcv_reg <= add_res;
                        default: ;
                    endcase
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_tready) begin
                    m_user_reg <= st_reg;
                    m_data_reg <= {(M_TDATA_W - 3 * DW - CNT_W)'(0), loaded_reg,
                                   ev_ok_reg ? sat32(rcv_reg) : DW'(0),
                                   ev_ok_reg ? sat32(rs_reg)  : DW'(0),
                                   ev_ok_reg ? sat32(rv_reg)  : DW'(0)};
                end
            end
            default: ;
        endcase
    end

endmodule

### sv/chse_checker.sv
// Port-level checker for the cubic Hermite spline evaluator, bound to the top level.
// Depends on chse_pkg.
module chse_checker
    import chse_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic [TUSER_W-1:0]   s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [TUSER_W-1:0]   m_tuser
);

    // A held result keeps its data
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Knot count never exceeds the table size
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[3*DW+CNT_W-1:3*DW] <= CNT_W'(MAX_KNOTS))
        else $error("knot count out of range");

    // Error results carry zero value, slope and convexity
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_OK |-> m_tdata[3*DW-1:0] == '0)
        else $error("error result with nonzero payload");

    // A full-table error only when the table is full
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_FULL |-> m_tdata[3*DW+CNT_W-1:3*DW] == CNT_W'(MAX_KNOTS))
        else $error("table-full status with room left");

endmodule

bind cubic_hermite_spline_eval chse_checker u_chse_checker (.*);

### test/tb_cubic_hermite_spline_eval.sv
// Self-checking testbench for cubic_hermite_spline_eval: directed and random knot/evaluate
// traffic with a bit-exact predictor and randomized handshake pressure on both streams.
// Depends on chse_pkg and the cubic_hermite_spline_eval RTL.
`timescale 1ns / 100ps

module tb_cubic_hermite_spline_eval;
    import chse_pkg::*;

    localparam int  N_ITEMS    = 1200;
    localparam int  HOLD_LEN   = 3000;
    localparam int  HOLD_AT    = 500;
    localparam int  DRAIN_WAIT = 300;
    localparam int  CYCLE_CAP  = 1500000;
    localparam logic [1:0] CMD_SPARE = 2'd3;

    typedef struct {
        logic [1:0]  cmd;
        logic [31:0] pos;
        logic [31:0] val;
        logic [31:0] slp;
        bit          drain;
    } request_t;

    typedef struct {
        logic [31:0] value;
        logic [31:0] slope;
        logic [31:0] conv;
        logic [1:0]  status;
        logic [6:0]  count;
    } answer_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;   // position, knot_value, knot_slope
    logic [TUSER_W-1:0]   s_tuser = '0;   // cmd
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;        // value, slope, convexity, knot_count, zero pad
    logic [TUSER_W-1:0]   m_tuser;        // status

    request_t pending_reqs[$];
    answer_t  expected_answers[$];
    int       sent_cnt = 0;
    int       hold_cnt = 0;
    bit       hold_done = 1'b0;
    bit       failed = 1'b0;
    longint   cycle_cnt = 0;

    // Predictor state: interval table and last-knot registers
    logic signed [63:0] iv_start[MAX_KNOTS];
    logic signed [63:0] iv_a[MAX_KNOTS];
    logic signed [63:0] iv_b[MAX_KNOTS];
    logic signed [63:0] iv_c[MAX_KNOTS];
    logic signed [63:0] iv_d[MAX_KNOTS];
    logic signed [63:0] tail_pos = 0, tail_val = 0, tail_slp = 0;
    int                 knots_loaded = 0;

    cubic_hermite_spline_eval dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // trunc(x*t / 2^F) on magnitudes, saturated to 2^63-1
    function automatic logic signed [63:0] fix_mul(input logic signed [63:0] x,
                                                   input logic signed [63:0] t);
        logic [127:0] ax, at, p;
        logic         neg;
        neg = x[63] ^ t[63];
        ax = {64'd0, (x[63] ? (~x + 64'd1) : x)};
        at = {64'd0, (t[63] ? (~t + 64'd1) : t)};
        p = (ax * at) >> FRAC_BITS;
        if (p > 128'h7FFF_FFFF_FFFF_FFFF) p = 128'h7FFF_FFFF_FFFF_FFFF;
        return neg ? -$signed(p[63:0]) : $signed(p[63:0]);
    endfunction

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] x,
                                                   input logic signed [63:0] y);
        logic signed [64:0] s;
        s = {x[63], x} + {y[63], y};
        if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
        if (s < -65'sh0_8000_0000_0000_0000) return {1'b1, 63'd0};
        return s[63:0];
    endfunction

    function automatic logic [31:0] clip32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    // (|num| << sh) / h^2 (and / h again for d), saturated to signed 48 bits
    function automatic logic signed [63:0] coef_quot(input logic signed [127:0] num,
                                                     input int sh, input logic [63:0] h,
                                                     input bit cube);
        logic [255:0] mag, hh, cap;
        logic         neg;
        neg = num[127];
        mag = {128'd0, (neg ? (~num + 128'd1) : num)};
        hh = {192'd0, h};
        mag = (mag << sh) / (hh * hh);
        if (cube) mag = mag / hh;
        cap = (256'd1 << 47) - 256'd1 + (neg ? 256'd1 : 256'd0);
        if (mag > cap) mag = cap;
        return neg ? -$signed({16'd0, mag[47:0]}) : $signed({16'd0, mag[47:0]});
    endfunction

    // Apply one request to the predictor and return the result it should produce
    function automatic answer_t spline_predict(input request_t r);
        answer_t            ans;
        logic signed [63:0] pos, y1, s1, v, s, cv, x, t, c, d, h;
        logic signed [127:0] nc, nd;
        int                 cnt, idx;
        pos = $signed(r.pos);
        y1 = $signed(r.val);
        s1 = $signed(r.slp);
        v = 0; s = 0; cv = 0;
        ans.status = ST_OK;
        case (r.cmd)
            CMD_CLEAR: begin
                knots_loaded = 0;
                tail_pos = 0; tail_val = 0; tail_slp = 0;
            end
            CMD_APPEND: begin
                if (knots_loaded >= MAX_KNOTS) begin
                    ans.status = ST_FULL;
                end else if (knots_loaded > 0 && pos <= tail_pos) begin
                    ans.status = ST_ORDER;
                end else begin
                    if (knots_loaded > 0) begin
                        h = pos - tail_pos;
                        nc = 128'(3 * (y1 - tail_val) * 65536)
                           - 128'($signed(h)) * 128'(2 * tail_slp + s1);
                        nd = 128'(2 * (tail_val - y1) * 65536)
                           + 128'($signed(h)) * 128'(tail_slp + s1);
                        idx = knots_loaded - 1;
                        iv_start[idx] = tail_pos;
                        iv_a[idx] = tail_val;
                        iv_b[idx] = tail_slp;
                        iv_c[idx] = coef_quot(nc, FRAC_BITS, h, 1'b0);
                        iv_d[idx] = coef_quot(nd, 2 * FRAC_BITS, h, 1'b1);
                    end
                    tail_pos = pos; tail_val = y1; tail_slp = s1;
                    knots_loaded++;
                end
            end
            CMD_EVAL: begin
                if (knots_loaded < 3) begin
                    ans.status = ST_FEW;
                end else begin
                    // clamp at the last knot, then pick the interval ending at or past x
                    x = (pos > tail_pos) ? tail_pos : pos;
                    cnt = 0;
                    for (int k = 0; k < knots_loaded - 1; k++)
                        if (iv_start[k] < x) cnt++;
                    idx = (cnt > 0) ? cnt - 1 : 0;
                    t = x - iv_start[idx];
                    c = iv_c[idx];
                    d = iv_d[idx];
                    v = sat_add(sat_add(iv_a[idx], fix_mul(iv_b[idx], t)),
                                sat_add(fix_mul(fix_mul(c, t), t),
                                        fix_mul(fix_mul(fix_mul(d, t), t), t)));
                    s = sat_add(sat_add(iv_b[idx], fix_mul(2 * c, t)),
                                fix_mul(fix_mul(3 * d, t), t));
                    cv = sat_add(2 * c, fix_mul(6 * d, t));
                end
            end
            default: ;
        endcase
        ans.value = clip32(v);
        ans.slope = clip32(s);
        ans.conv = clip32(cv);
        ans.count = 7'(knots_loaded);
        return ans;
    endfunction

    function automatic int idle_phase();
        if (sent_cnt < N_ITEMS / 3) return 0;
        if (sent_cnt < 2 * N_ITEMS / 3) return 1;
        return 2;
    endfunction

    // Request driver
    always @(posedge aclk) begin
        int  pct;
        bit  go;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            pct = (idle_phase() == 0) ? 72 : (idle_phase() == 1) ? 24 : 100;
            go = ($urandom_range(0, 99) < pct);
            if (pending_reqs.size() > 0 && go
                && !(pending_reqs[0].drain && expected_answers.size() > 0)) begin
                request_t r;
                r = pending_reqs.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {r.slp, r.val, r.pos};
                s_tuser <= r.cmd;
                expected_answers.push_back(spline_predict(r));
                sent_cnt <= sent_cnt + 1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off once, in the middle of the run
    always @(posedge aclk) begin
        if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
        end else if (!hold_done && sent_cnt >= HOLD_AT) begin
            hold_cnt <= HOLD_LEN;
            hold_done <= 1'b1;
        end
    end

    // Result ready
    always @(posedge aclk) begin
        int pct;
        pct = (idle_phase() == 0) ? 24 : (idle_phase() == 1) ? 72 : 100;
        if (!aresetn || hold_cnt > 0) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) < pct);
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        answer_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_answers.size() == 0) begin
                $display("%0t: unexpected result tdata=%h tuser=%h", $time, m_tdata, m_tuser);
                failed = 1'b1;
            end else begin
                want = expected_answers.pop_front();
                if (m_tdata[31:0] !== want.value) begin
                    $display("%0t: value expected %h got %h", $time, want.value, m_tdata[31:0]);
                    failed = 1'b1;
                end
                if (m_tdata[63:32] !== want.slope) begin
                    $display("%0t: slope expected %h got %h", $time, want.slope,
                             m_tdata[63:32]);
                    failed = 1'b1;
                end
                if (m_tdata[95:64] !== want.conv) begin
                    $display("%0t: convexity expected %h got %h", $time, want.conv,
                             m_tdata[95:64]);
                    failed = 1'b1;
                end
                if (m_tdata[102:96] !== want.count) begin
                    $display("%0t: knot_count expected %0d got %0d", $time, want.count,
                             m_tdata[102:96]);
                    failed = 1'b1;
                end
                if (m_tuser !== want.status) begin
                    $display("%0t: status expected %0d got %0d", $time, want.status, m_tuser);
                    failed = 1'b1;
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_CAP) begin
            $display("tb_cubic_hermite_spline_eval NOT OK");
            $finish;
        end
    end

    task automatic add_req(input logic [1:0] cmd, input logic [31:0] pos,
                           input logic [31:0] val, input logic [31:0] slp, input bit drain);
        request_t r;
        r.cmd = cmd; r.pos = pos; r.val = val; r.slp = slp; r.drain = drain;
        pending_reqs.push_back(r);
    endtask

    function automatic logic [31:0] rand_q16();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
            2: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    // One clear, a run of increasing knots with some noise, then a few evaluations
    task automatic add_spline(input bit drain);
        longint knot_pos[$];
        longint p, step, span, q;
        int     n, m, sel;
        sel = $urandom_range(0, 9);
        n = (sel == 0) ? $urandom_range(0, 2) : (sel == 1) ? $urandom_range(60, 66)
                                                            : $urandom_range(3, 10);
        add_req(CMD_CLEAR, $urandom, $urandom, $urandom, drain);
        p = ($urandom_range(0, 7) == 0) ? longint'($signed($urandom))
                                        : longint'($urandom_range(0, 1 << 22)) - (1 << 21);
        for (int k = 0; k < n; k++) begin
            if (k > 0) begin
                case ($urandom_range(0, 5))
                    0: step = 1;
                    1: step = $urandom_range(1, 1 << 30);
                    default: step = $urandom_range(1 << 12, 1 << 18);
                endcase
                p = p + step;
                if (p > 64'sd2147483647) break;
            end
            add_req(CMD_APPEND, 32'(p), rand_q16(), rand_q16(), 1'b0);
            knot_pos.push_back(p);
            // out-of-order or repeated position
            if ($urandom_range(0, 11) == 0)
                add_req(CMD_APPEND, 32'(p - $urandom_range(0, 1 << 16)), $urandom, $urandom,
                        1'b0);
            if ($urandom_range(0, 29) == 0)
                add_req(CMD_SPARE, $urandom, $urandom, $urandom, 1'b0);
        end
        m = $urandom_range(2, 8);
        for (int j = 0; j < m; j++) begin
            if (knot_pos.size() == 0) begin
                q = longint'($signed($urandom));
            end else begin
                span = knot_pos[$] - knot_pos[0];
                case ($urandom_range(0, 5))
                    0: q = knot_pos[$urandom_range(0, knot_pos.size() - 1)];
                    1: q = knot_pos[0] - $urandom_range(1, 1 << 20);
                    2: q = knot_pos[$] + $urandom_range(0, 1 << 20);
                    3: q = longint'($signed($urandom));
                    default: q = knot_pos[0] + (longint'($urandom) % (span + 1));
                endcase
                if (q < -64'sd2147483648) q = -64'sd2147483648;
                if (q > 64'sd2147483647) q = 64'sd2147483647;
            end
            add_req(CMD_EVAL, 32'(q), $urandom, $urandom, 1'b0);
        end
    endtask

    localparam logic [31:0] ONE = 32'h0001_0000;

    initial begin
        // extremes: widest possible intervals and saturating coefficients
        add_req(CMD_EVAL, 32'h0, 32'h0, 32'h0, 1'b0);
        add_req(CMD_APPEND, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        add_req(CMD_EVAL, 32'h0, 32'h0, 32'h0, 1'b0);
        add_req(CMD_APPEND, 32'h8000_0000, 32'h1, 32'h1, 1'b0);
        add_req(CMD_APPEND, 32'h8001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        add_req(CMD_EVAL, 32'h8000_8000, 32'h0, 32'h0, 1'b0);
        add_req(CMD_APPEND, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b0);
        add_req(CMD_EVAL, 32'h8000_0000, 32'h0, 32'h0, 1'b0);
        add_req(CMD_EVAL, 32'h8001_0000, 32'h0, 32'h0, 1'b0);
        add_req(CMD_EVAL, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        add_req(CMD_EVAL, 32'h0, 32'h0, 32'h0, 1'b0);
        add_req(CMD_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        add_req(CMD_CLEAR, 32'h0, 32'h0, 32'h0, 1'b0);
        // a gentle spline: below first, on inner knots, between, past last
        add_req(CMD_APPEND, 32'h0, 32'h0, ONE, 1'b0);
        add_req(CMD_APPEND, ONE, ONE, 32'h0, 1'b0);
        add_req(CMD_APPEND, 2 * ONE, 32'h0, -ONE, 1'b0);
        add_req(CMD_APPEND, 3 * ONE, -ONE, 32'h0, 1'b0);
        add_req(CMD_EVAL, -2 * ONE, 32'h0, 32'h0, 1'b0);
        add_req(CMD_EVAL, ONE, 32'h0, 32'h0, 1'b0);
        add_req(CMD_EVAL, 2 * ONE, 32'h0, 32'h0, 1'b0);
        add_req(CMD_EVAL, ONE + 32'h8000, 32'h0, 32'h0, 1'b0);
        add_req(CMD_EVAL, 10 * ONE, 32'h0, 32'h0, 1'b0);
        add_req(CMD_APPEND, 3 * ONE, 32'h0, 32'h0, 1'b0);
        add_req(CMD_CLEAR, 32'h0, 32'h0, 32'h0, 1'b0);
        add_req(CMD_EVAL, ONE, 32'h0, 32'h0, 1'b0);
        // random splines; the first one waits for an empty pipeline, another later on
        add_spline(1'b1);
        while (pending_reqs.size() < N_ITEMS)
            add_spline(pending_reqs.size() > 850 && pending_reqs.size() < 870);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        while (pending_reqs.size() > 0 || s_tvalid || expected_answers.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (!failed) begin
            $display("tb_cubic_hermite_spline_eval OK");
        end else begin
            $display("tb_cubic_hermite_spline_eval NOT OK");
        end
        $finish;
    end

endmodule
